// ----- hdl/twmc_pkg.sv -----
// Shared types and constants of the two-wheel motion controller.
// Used by twmc_ctrl, twmc_datapath and the top level; no dependencies.
`default_nettype none

package twmc_pkg;

  localparam int DUTY_BITS_DEF = 16;
  localparam int TIME_BITS_DEF = 32;

  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;

  localparam int SPEED_W     = 7;
  localparam int TRIM_W      = 8;
  localparam int DUTY_W      = 16;
  localparam int PULSE_W     = 16;
  localparam int COUNT_W     = 32;
  localparam int NOW_W       = 32;
  localparam int SCALE_W     = DUTY_W + SPEED_W;
  localparam int TRIM_PROD_W = SCALE_W + TRIM_W;
  localparam int RECIP_W     = 2 * TRIM_PROD_W + 1;
  localparam int QUOT_W      = 18;

  // floor(x / 10000) == (x * RECIP_MULT) >> RECIP_SHIFT, exact for x < 2^31
  localparam logic [31:0] RECIP_MULT  = 32'd3518437209;
  localparam int          RECIP_SHIFT = 45;

  localparam logic [CFG_IDX_W-1:0] REG_FWD_SPEED  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TURN_SPEED = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LEFT_TRIM  = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT_TRIM = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_DUTY   = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_DUTY   = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_TURN_PULSE = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_PIVOT      = 4'd7;

  typedef enum logic [1:0] {
    OP_MOTION = 2'd0,
    OP_TICK   = 2'd1,
    OP_ESTOP  = 2'd2,
    OP_CLEAR  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    MS_STOP  = 2'd0,
    MS_FWD   = 2'd1,
    MS_LEFT  = 2'd2,
    MS_RIGHT = 2'd3
  } motion_e;

  typedef enum logic [1:0] {
    CAUSE_NONE  = 2'd0,
    CAUSE_CMD   = 2'd1,
    CAUSE_WDOG  = 2'd2,
    CAUSE_ESTOP = 2'd3
  } cause_e;

  typedef struct packed {
    logic apply;
    logic mul_scale;
    logic mul_trim;
    logic mul_recip;
    logic clamp;
    logic side;
    logic emit;
  } twmc_cmd_t;

  typedef struct packed {
    logic out_busy;
  } twmc_sts_t;

endpackage

`default_nettype wire

// ----- hdl/twmc_ctrl.sv -----
// Sequencer of the motion controller: accepts a transaction and steps the
// datapath through the duty computation of both sides. Uses twmc_pkg.
`default_nettype none

module twmc_ctrl import twmc_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire twmc_sts_t sts_i,
  output twmc_cmd_t      cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCALE,
    ST_TRIM,
    ST_RECIP,
    ST_CLAMP,
    ST_EMIT
  } state_e;

  state_e state_q;
  logic   side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      side_q  <= 1'b0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            state_q <= ST_SCALE;
            side_q  <= 1'b0;
          end
        end
        ST_SCALE: state_q <= ST_TRIM;
        ST_TRIM:  state_q <= ST_RECIP;
        ST_RECIP: state_q <= ST_CLAMP;
        ST_CLAMP: begin
          if (side_q) begin
            state_q <= ST_EMIT;
          end else begin
            side_q  <= 1'b1;
            state_q <= ST_TRIM;
          end
        end
        ST_EMIT: begin
          if (!sts_i.out_busy) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd_o           = '0;
    cmd_o.apply     = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.mul_scale = (state_q == ST_SCALE);
    cmd_o.mul_trim  = (state_q == ST_TRIM);
    cmd_o.mul_recip = (state_q == ST_RECIP);
    cmd_o.clamp     = (state_q == ST_CLAMP);
    cmd_o.side      = side_q;
    cmd_o.emit      = (state_q == ST_EMIT) && !sts_i.out_busy;
  end

  assign in_stall_o = (state_q != ST_IDLE);

  a_apply_then_scale: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.apply |=> cmd_o.mul_scale)
    else $error("scale step did not follow accepted transaction");

  a_one_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.apply, cmd_o.mul_scale, cmd_o.mul_trim, cmd_o.mul_recip,
              cmd_o.clamp, cmd_o.emit}))
    else $error("more than one datapath step issued");

  a_right_after_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.clamp && !cmd_o.side) |=> (cmd_o.mul_trim && cmd_o.side))
    else $error("right side did not follow left side");

endmodule

`default_nettype wire

// ----- hdl/twmc_datapath.sv -----
// Datapath of the motion controller: configuration and motion state, the
// shared duty multiplier chain, clamping and the result register. Uses twmc_pkg.
`default_nettype none

module twmc_datapath import twmc_pkg::*; #(
  parameter int DUTY_BITS = DUTY_BITS_DEF,
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire twmc_cmd_t             cmd_i,
  output twmc_sts_t                  sts_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic [1:0]            operation_i,
  input  wire logic [1:0]            requested_state_i,
  input  wire logic [1:0]            stop_cause_in_i,
  input  wire logic [NOW_W-1:0]      now_ms_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic                       left_forward_o,
  output logic                       left_reverse_o,
  output logic [DUTY_W-1:0]          left_duty_o,
  output logic                       right_forward_o,
  output logic                       right_reverse_o,
  output logic [DUTY_W-1:0]          right_duty_o,
  output logic [1:0]                 motion_state_o,
  output logic [1:0]                 resume_state_o,
  output logic [1:0]                 stop_cause_o,
  output logic                       estop_held_o,
  output logic [COUNT_W-1:0]         transition_total_o,
  output logic [COUNT_W-1:0]         turn_total_o
);

  localparam logic [QUOT_W-1:0] DUTY_CAP = QUOT_W'((2 ** DUTY_BITS) - 1);

  // configuration
  logic [SPEED_W-1:0] fwd_speed_q, turn_speed_q;
  logic [TRIM_W-1:0]  left_trim_q, right_trim_q;
  logic [DUTY_W-1:0]  max_duty_q, min_duty_q;
  logic [PULSE_W-1:0] turn_pulse_q;
  logic               pivot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_speed_q  <= SPEED_W'(60);
      turn_speed_q <= SPEED_W'(50);
      left_trim_q  <= TRIM_W'(100);
      right_trim_q <= TRIM_W'(100);
      max_duty_q   <= DUTY_W'(255);
      min_duty_q   <= DUTY_W'(80);
      turn_pulse_q <= PULSE_W'(300);
      pivot_q      <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_FWD_SPEED:  fwd_speed_q  <= cfg_data_i[SPEED_W-1:0];
        REG_TURN_SPEED: turn_speed_q <= cfg_data_i[SPEED_W-1:0];
        REG_LEFT_TRIM:  left_trim_q  <= cfg_data_i[TRIM_W-1:0];
        REG_RIGHT_TRIM: right_trim_q <= cfg_data_i[TRIM_W-1:0];
        REG_MAX_DUTY:   max_duty_q   <= cfg_data_i[DUTY_W-1:0];
        REG_MIN_DUTY:   min_duty_q   <= cfg_data_i[DUTY_W-1:0];
        REG_TURN_PULSE: turn_pulse_q <= cfg_data_i[PULSE_W-1:0];
        REG_PIVOT:      pivot_q      <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // motion state
  motion_e              motion_q, motion_d, resume_q, resume_d, next_motion;
  cause_e               cause_q, cause_d;
  logic                 latch_q, latch_d;
  logic [TIME_BITS-1:0] start_q, start_d;
  logic [COUNT_W-1:0]   trans_q, trans_d, turns_q, turns_d;

  op_e                  op;
  motion_e              req;
  cause_e               cause_in;
  logic [TIME_BITS-1:0] now_t, elapsed;
  logic                 turning;

  always_comb begin
    op          = op_e'(operation_i);
    req         = motion_e'(requested_state_i);
    cause_in    = cause_e'(stop_cause_in_i);
    now_t       = now_ms_i[TIME_BITS-1:0];
    elapsed     = now_t - start_q;
    turning     = (motion_q == MS_LEFT) || (motion_q == MS_RIGHT);
    motion_d    = motion_q;
    resume_d    = resume_q;
    cause_d     = cause_q;
    latch_d     = latch_q;
    start_d     = start_q;
    trans_d     = trans_q;
    turns_d     = turns_q;
    next_motion = motion_q;
    if (cmd_i.apply) begin
      unique case (op)
        OP_MOTION: begin
          if (!(latch_q && req != MS_STOP)) begin
            case (req) inside
              MS_STOP: begin
                resume_d    = MS_STOP;
                start_d     = '0;
                next_motion = MS_STOP;
                if (!latch_q) begin
                  cause_d = CAUSE_CMD;
                end
              end
              MS_FWD: begin
                resume_d = MS_FWD;
                cause_d  = CAUSE_NONE;
                if (!turning) begin
                  next_motion = MS_FWD;
                end
              end
              MS_LEFT, MS_RIGHT: begin
                cause_d = CAUSE_NONE;
                if (motion_q != req) begin
                  start_d     = now_t;
                  turns_d     = turns_q + COUNT_W'(1);
                  next_motion = req;
                end
              end
              default: ;
            endcase
          end
        end
        OP_TICK: begin
          if (turning && (elapsed >= TIME_BITS'(turn_pulse_q))) begin
            next_motion = latch_q ? MS_STOP : resume_q;
          end
        end
        OP_ESTOP: begin
          latch_d     = (cause_in == CAUSE_ESTOP);
          resume_d    = MS_STOP;
          start_d     = '0;
          cause_d     = cause_in;
          next_motion = MS_STOP;
        end
        OP_CLEAR: begin
          latch_d = 1'b0;
          if (cause_q == CAUSE_ESTOP) begin
            cause_d = CAUSE_CMD;
          end
        end
        default: ;
      endcase
      if (next_motion != motion_q) begin
        trans_d = trans_q + COUNT_W'(1);
      end
      motion_d = next_motion;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      motion_q <= MS_STOP;
      resume_q <= MS_STOP;
      cause_q  <= CAUSE_NONE;
      latch_q  <= 1'b0;
      start_q  <= '0;
      trans_q  <= '0;
      turns_q  <= '0;
    end else begin
      motion_q <= motion_d;
      resume_q <= resume_d;
      cause_q  <= cause_d;
      latch_q  <= latch_d;
      start_q  <= start_d;
      trans_q  <= trans_d;
      turns_q  <= turns_d;
    end
  end

  // duty = max_duty * speed * trim / 10000, one multiply per step; a nonzero duty is clamped to min/max
  logic [SCALE_W-1:0]     scale_q;
  logic [TRIM_PROD_W-1:0] trim_q;
  logic [RECIP_W-1:0]     recip_q;
  logic [DUTY_W-1:0]      duty_l_q, duty_r_q;
  logic [SPEED_W-1:0]     speed_sel;
  logic [TRIM_W-1:0]      trim_sel;
  logic [QUOT_W-1:0]      quot, clamped;

  always_comb begin
    speed_sel = (motion_q == MS_FWD) ? fwd_speed_q : turn_speed_q;
    trim_sel  = cmd_i.side ? right_trim_q : left_trim_q;
    quot      = recip_q[RECIP_SHIFT +: QUOT_W];
    clamped   = quot;
    if (quot != '0) begin
      if (clamped < QUOT_W'(min_duty_q)) begin
        clamped = QUOT_W'(min_duty_q);
      end
      if (clamped > QUOT_W'(max_duty_q)) begin
        clamped = QUOT_W'(max_duty_q);
      end
      if (clamped > DUTY_CAP) begin
        clamped = DUTY_CAP;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_scale) begin
      scale_q <= SCALE_W'(max_duty_q) * SCALE_W'(speed_sel);
    end
    if (cmd_i.mul_trim) begin
      trim_q <= TRIM_PROD_W'(scale_q) * TRIM_PROD_W'(trim_sel);
    end
    if (cmd_i.mul_recip) begin
      recip_q <= RECIP_W'(trim_q) * RECIP_W'(RECIP_MULT);
    end
    if (cmd_i.clamp) begin
      if (cmd_i.side) begin
        duty_r_q <= clamped[DUTY_W-1:0];
      end else begin
        duty_l_q <= clamped[DUTY_W-1:0];
      end
    end
  end

  // bridge drive from the motion state
  logic l_fwd, l_rev, r_fwd, r_rev, l_on, r_on;

  always_comb begin
    l_fwd = 1'b0;
    l_rev = 1'b0;
    r_fwd = 1'b0;
    r_rev = 1'b0;
    unique case (motion_q)
      MS_FWD: begin
        l_fwd = 1'b1;
        r_fwd = 1'b1;
      end
      MS_LEFT: begin
        l_rev = pivot_q;
        r_fwd = 1'b1;
      end
      MS_RIGHT: begin
        l_fwd = 1'b1;
        r_rev = pivot_q;
      end
      default: ;
    endcase
    l_on = (l_fwd || l_rev) && (duty_l_q != '0);
    r_on = (r_fwd || r_rev) && (duty_r_q != '0);
  end

  // result register
  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      left_forward_o     <= l_on && l_fwd;
      left_reverse_o     <= l_on && l_rev;
      left_duty_o        <= l_on ? duty_l_q : '0;
      right_forward_o    <= r_on && r_fwd;
      right_reverse_o    <= r_on && r_rev;
      right_duty_o       <= r_on ? duty_r_q : '0;
      motion_state_o     <= motion_q;
      resume_state_o     <= resume_q;
      stop_cause_o       <= cause_q;
      estop_held_o       <= latch_q;
      transition_total_o <= trans_q;
      turn_total_o       <= turns_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign sts_o.out_busy = out_valid_q && out_stall_i;

  a_valid_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(cmd_i.emit))
    else $error("result valid without emit step");

  a_left_pins: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (left_forward_o || left_reverse_o)) |->
      (!(left_forward_o && left_reverse_o) && (left_duty_o != '0)))
    else $error("left bridge pins inconsistent with duty");

  a_right_pins: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (right_forward_o || right_reverse_o)) |->
      (!(right_forward_o && right_reverse_o) && (right_duty_o != '0)))
    else $error("right bridge pins inconsistent with duty");

endmodule

`default_nettype wire

// ----- hdl/two_wheel_motion_controller_unit.sv -----
// Two-wheel H-bridge motion controller: one result per transaction.
// The result is registered at the emit step. The shared multiplier chain
// runs scale once, then trim, reciprocal and clamp once per bridge side; an
// output stall holds the emit step. A new transaction waits for idle.
// Reset: asynchronous, active low; restores register defaults and stop state.
// Depends on twmc_pkg, twmc_ctrl and twmc_datapath.
`default_nettype none

module two_wheel_motion_controller_unit import twmc_pkg::*; #(
  parameter int DUTY_BITS = DUTY_BITS_DEF,
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic [1:0]            operation_i,
  input  wire logic [1:0]            requested_state_i,
  input  wire logic [1:0]            stop_cause_in_i,
  input  wire logic [NOW_W-1:0]      now_ms_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic                       left_forward_o,
  output logic                       left_reverse_o,
  output logic [DUTY_W-1:0]          left_duty_o,
  output logic                       right_forward_o,
  output logic                       right_reverse_o,
  output logic [DUTY_W-1:0]          right_duty_o,
  output logic [1:0]                 motion_state_o,
  output logic [1:0]                 resume_state_o,
  output logic [1:0]                 stop_cause_o,
  output logic                       estop_held_o,
  output logic [COUNT_W-1:0]         transition_total_o,
  output logic [COUNT_W-1:0]         turn_total_o
);

  twmc_cmd_t cmd;
  twmc_sts_t sts;

  twmc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  twmc_datapath #(
    .DUTY_BITS (DUTY_BITS),
    .TIME_BITS (TIME_BITS)
  ) u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .cfg_we_i           (cfg_we_i),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .operation_i        (operation_i),
    .requested_state_i  (requested_state_i),
    .stop_cause_in_i    (stop_cause_in_i),
    .now_ms_i           (now_ms_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .left_forward_o     (left_forward_o),
    .left_reverse_o     (left_reverse_o),
    .left_duty_o        (left_duty_o),
    .right_forward_o    (right_forward_o),
    .right_reverse_o    (right_reverse_o),
    .right_duty_o       (right_duty_o),
    .motion_state_o     (motion_state_o),
    .resume_state_o     (resume_state_o),
    .stop_cause_o       (stop_cause_o),
    .estop_held_o       (estop_held_o),
    .transition_total_o (transition_total_o),
    .turn_total_o       (turn_total_o)
  );

endmodule

`default_nettype wire
